// ===== rtl/core/kmw_pkg.sv =====
// Package for the minimum spanning forest weight block.
// Holds the shared widths, status bit positions and the structs between the modules.
// Depends on nothing; the top level, the engine and the testbench use it.
`default_nettype none
package kmw_pkg;

    localparam int NODE_BITS   = 10;
    localparam int WEIGHT_BITS = 16;
    localparam int SUM_BITS    = 28;
    localparam int SIZE_BITS   = 11;
    localparam int EDGE_AW     = 12;
    localparam int CNT_BITS    = EDGE_AW + 1;
    localparam int POS_BITS    = CNT_BITS + 1;
    localparam int STATUS_BITS = 2;
    localparam int EDGE_BITS   = 2 * NODE_BITS + WEIGHT_BITS;

    localparam logic [CNT_BITS-1:0]  MAX_EDGES        = CNT_BITS'(1 << EDGE_AW);
    localparam logic [NODE_BITS-1:0] NODE_COUNT_RESET = '1;

    localparam int FLAG_DROP  = 0;
    localparam int FLAG_RANGE = 1;

    typedef struct packed {
        logic [NODE_BITS-1:0]          na;
        logic [NODE_BITS-1:0]          nb;
        logic signed [WEIGHT_BITS-1:0] w;
    } t_edge;

    typedef struct packed {
        logic               we;
        logic [EDGE_AW-1:0] addr;
        t_edge              data;
    } t_load;

    typedef struct packed {
        logic                go;
        logic [CNT_BITS-1:0] n;
    } t_start;

    typedef struct packed {
        logic                       idle;
        logic                       done;
        logic signed [SUM_BITS-1:0] sum;
    } t_eng_stat;

endpackage
`default_nettype wire

// ===== rtl/core/kruskal_mst_weight_top.sv =====
// Top level of the minimum spanning forest weight block.
// Takes in edges, keeps node_count and the status, and holds the result register.
// Depends on kmw_pkg and kmw_engine.
//
// Edges come in on the input channel (i_in_valid, o_in_stall), one beat per edge, one
// beat per cycle while loading. A beat with i_last_edge set starts the computation and
// the input stalls until it is done. The engine merge sorts the stored edges in
// ceil(log2(edges)) passes, then scans them in order with union-find using path halving.
// One beat on the output channel (o_out_valid, i_out_stall) carries o_tree_weight and
// o_status; it waits in an output register while the receiver stalls, and the engine
// holds its result until that register is free. After reset and after every result, a
// clearing pass over all 1024 entries resets the union-find memories, during which no
// edge is taken. node_count is written on the configuration channel (i_cfg_valid,
// o_cfg_ready); the user must write it only while the block is idle, and the block itself
// does not enforce this. It keeps its value across results and returns to 1023 at reset.
`default_nettype none
module kruskal_mst_weight_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [kmw_pkg::NODE_BITS-1:0]        i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [kmw_pkg::NODE_BITS-1:0]        i_node_a,
    input  wire logic [kmw_pkg::NODE_BITS-1:0]        i_node_b,
    input  wire logic signed [kmw_pkg::WEIGHT_BITS-1:0] i_edge_weight,
    input  wire logic                                 i_last_edge,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [kmw_pkg::SUM_BITS-1:0]       o_tree_weight,
    output logic [kmw_pkg::STATUS_BITS-1:0]           o_status
);

    logic [kmw_pkg::NODE_BITS-1:0]   r_node_count;
    logic [kmw_pkg::CNT_BITS-1:0]    r_total;
    logic [kmw_pkg::STATUS_BITS-1:0] r_flags;
    logic [kmw_pkg::STATUS_BITS-1:0] r_res_flags;
    logic                            r_out_valid;
    logic signed [kmw_pkg::SUM_BITS-1:0] r_out_weight;
    logic [kmw_pkg::STATUS_BITS-1:0] r_out_status;

    logic [kmw_pkg::STATUS_BITS-1:0] n_flags;
    logic [kmw_pkg::CNT_BITS-1:0]    n_total;
    logic                            accept;
    logic                            bad_range;
    logic                            full;
    logic                            ack;
    kmw_pkg::t_load                  load;
    kmw_pkg::t_start                 start;
    kmw_pkg::t_eng_stat              stat;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !stat.idle;
    assign accept      = i_in_valid && !o_in_stall;
    assign bad_range   = (i_node_a > r_node_count) || (i_node_b > r_node_count);
    assign full        = (r_total == kmw_pkg::MAX_EDGES);

    always_comb begin
        n_flags = r_flags;
        n_total = r_total;
        if (accept) begin
            if (bad_range) begin
                n_flags[kmw_pkg::FLAG_RANGE] = 1'b1;
            end else if (full) begin
                n_flags[kmw_pkg::FLAG_DROP] = 1'b1;
            end else begin
                n_total = r_total + 1'b1;
            end
        end
    end

    assign load.we     = accept && !bad_range && !full;
    assign load.addr   = r_total[kmw_pkg::EDGE_AW-1:0];
    assign load.data   = '{na: i_node_a, nb: i_node_b, w: i_edge_weight};
    assign start.go    = accept && i_last_edge;
    assign start.n     = n_total;
    assign ack         = stat.done && (!r_out_valid || !i_out_stall);

    kmw_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_start (start),
        .i_ack   (ack),
        .o_stat  (stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= kmw_pkg::NODE_COUNT_RESET;
            r_total      <= '0;
            r_flags      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_node_count <= i_cfg_data;
            end
            if (start.go) begin
                r_total     <= '0;
                r_flags     <= '0;
                r_res_flags <= n_flags;
            end else begin
                r_total <= n_total;
                r_flags <= n_flags;
            end
            if (ack) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ack) begin
            r_out_weight <= stat.sum;
            r_out_status <= r_res_flags;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tree_weight = r_out_weight;
    assign o_status      = r_out_status;

endmodule
`default_nettype wire

// ===== rtl/core/kmw_ram.sv =====
// Generic single write port, single read port memory with registered read data.
// Depends on nothing.
`default_nettype none
module kmw_ram #(
    parameter int AW = 10,
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [(1 << AW)];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/kmw_engine.sv =====
// Sequencer that merge sorts the edge store by weight and runs union-find over it.
// Holds edge stores A and B, the parent and size memories; uses kmw_pkg and kmw_ram.
`default_nettype none
module kmw_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire kmw_pkg::t_load     i_load,
    input  wire kmw_pkg::t_start    i_start,
    input  wire logic               i_ack,
    output kmw_pkg::t_eng_stat      o_stat
);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_PASS  = 5'd2;
    localparam logic [4:0] S_RDP0  = 5'd3;
    localparam logic [4:0] S_RDQ0  = 5'd4;
    localparam logic [4:0] S_WAITQ = 5'd5;
    localparam logic [4:0] S_MERGE = 5'd6;
    localparam logic [4:0] S_LOAD  = 5'd7;
    localparam logic [4:0] S_NEXT  = 5'd8;
    localparam logic [4:0] S_SRD   = 5'd9;
    localparam logic [4:0] S_SGET  = 5'd10;
    localparam logic [4:0] S_FRD   = 5'd11;
    localparam logic [4:0] S_FCHK  = 5'd12;
    localparam logic [4:0] S_FHALF = 5'd13;
    localparam logic [4:0] S_CMPR  = 5'd14;
    localparam logic [4:0] S_SZB   = 5'd15;
    localparam logic [4:0] S_SZW   = 5'd16;
    localparam logic [4:0] S_UNI   = 5'd17;
    localparam logic [4:0] S_NEXTE = 5'd18;
    localparam logic [4:0] S_DONE  = 5'd19;

    localparam int NB = kmw_pkg::NODE_BITS;
    localparam int CB = kmw_pkg::CNT_BITS;
    localparam int PB = kmw_pkg::POS_BITS;
    localparam int AB = kmw_pkg::EDGE_AW;
    localparam int SB = kmw_pkg::SIZE_BITS;

    logic [4:0]  r_state;
    logic [4:0]  n_state;
    logic [CB-1:0] r_n;
    logic [PB-1:0] r_width;
    logic [PB-1:0] r_lo;
    logic [PB-1:0] r_mid;
    logic [PB-1:0] r_hi;
    logic [PB-1:0] r_p;
    logic [PB-1:0] r_q;
    logic [PB-1:0] r_k;
    logic [CB-1:0] r_i;
    logic        r_src_b;
    logic        r_took_q;
    kmw_pkg::t_edge r_dp;
    kmw_pkg::t_edge r_dq;
    kmw_pkg::t_edge r_e;
    logic [NB-1:0] r_x;
    logic          r_which;
    logic [NB-1:0] r_ra;
    logic [NB-1:0] r_rb;
    logic [SB-1:0] r_sa;
    logic [SB-1:0] r_sb;
    logic [NB-1:0] r_c;
    logic signed [kmw_pkg::SUM_BITS-1:0] r_sum;

    kmw_pkg::t_edge rd_a;
    kmw_pkg::t_edge rd_b;
    kmw_pkg::t_edge rd_e;
    logic [kmw_pkg::EDGE_BITS-1:0] rd_a_raw;
    logic [kmw_pkg::EDGE_BITS-1:0] rd_b_raw;
    logic [AB-1:0] e_raddr;
    logic          take_q;
    logic          p_ok;
    logic          q_ok;
    kmw_pkg::t_edge take_e;
    logic          we_a;
    logic          we_b;
    logic [AB-1:0] wa_e;
    kmw_pkg::t_edge wd_e;

    logic [NB-1:0] p_raddr;
    logic [NB-1:0] p_rdata;
    logic          p_we;
    logic [NB-1:0] p_waddr;
    logic [NB-1:0] p_wdata;
    logic [NB-1:0] s_raddr;
    logic [SB-1:0] s_rdata;
    logic          s_we;
    logic [NB-1:0] s_waddr;
    logic [SB-1:0] s_wdata;

    logic [PB-1:0] n_wide;
    logic [PB-1:0] lo_next;
    logic [PB-1:0] w_next;
    logic [PB-1:0] mid_raw;
    logic [PB-1:0] hi_raw;
    logic          a_small;

    assign rd_a   = kmw_pkg::t_edge'(rd_a_raw);
    assign rd_b   = kmw_pkg::t_edge'(rd_b_raw);
    assign rd_e   = r_src_b ? rd_b : rd_a;
    assign n_wide = PB'(r_n);
    assign p_ok   = r_p < r_mid;
    assign q_ok   = r_q < r_hi;
    assign take_q = q_ok && (!p_ok || (r_dq.w < r_dp.w));
    assign take_e = take_q ? r_dq : r_dp;
    assign lo_next = r_lo + (r_width << 1);
    assign w_next  = r_width << 1;
    assign mid_raw = r_lo + r_width;
    assign hi_raw  = r_lo + (r_width << 1);
    assign a_small = r_sa < r_sb;

    always_comb begin
        unique case (r_state)
            S_RDP0:  e_raddr = r_p[AB-1:0];
            S_RDQ0:  e_raddr = r_q[AB-1:0];
            S_MERGE: e_raddr = take_q ? AB'(r_q + 1'b1) : AB'(r_p + 1'b1);
            S_SRD:   e_raddr = r_i[AB-1:0];
            default: e_raddr = r_p[AB-1:0];
        endcase
    end

    always_comb begin
        we_a = 1'b0;
        we_b = 1'b0;
        wa_e = r_k[AB-1:0];
        wd_e = take_e;
        if (r_state == S_IDLE) begin
            we_a = i_load.we;
            wa_e = i_load.addr;
            wd_e = i_load.data;
        end else if (r_state == S_MERGE) begin
            we_a = r_src_b;
            we_b = !r_src_b;
        end
    end

    always_comb begin
        unique case (r_state)
            S_FCHK:  p_raddr = p_rdata;
            default: p_raddr = r_x;
        endcase
        p_we    = 1'b0;
        p_waddr = r_x;
        p_wdata = p_rdata;
        s_we    = 1'b0;
        s_waddr = r_c;
        s_wdata = SB'(1);
        s_raddr = (r_state == S_SZB) ? r_rb : r_ra;
        unique case (r_state)
            S_FHALF: begin
                p_we = 1'b1;
            end
            S_UNI: begin
                p_we    = 1'b1;
                p_waddr = a_small ? r_ra : r_rb;
                p_wdata = a_small ? r_rb : r_ra;
                s_we    = 1'b1;
                s_waddr = a_small ? r_rb : r_ra;
                s_wdata = r_sa + r_sb;
            end
            S_CLR: begin
                p_we    = 1'b1;
                p_waddr = r_c;
                p_wdata = r_c;
                s_we    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    kmw_ram #(.AW(AB), .DW(kmw_pkg::EDGE_BITS)) u_store_a (
        .i_clk(i_clk), .i_we(we_a), .i_waddr(wa_e), .i_wdata(wd_e),
        .i_raddr(e_raddr), .o_rdata(rd_a_raw)
    );

    kmw_ram #(.AW(AB), .DW(kmw_pkg::EDGE_BITS)) u_store_b (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(wa_e), .i_wdata(wd_e),
        .i_raddr(e_raddr), .o_rdata(rd_b_raw)
    );

    kmw_ram #(.AW(NB), .DW(NB)) u_parent (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    kmw_ram #(.AW(NB), .DW(SB)) u_size (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:   if (r_c == '1) n_state = S_IDLE;
            S_IDLE: begin
                if (i_start.go) begin
                    if (i_start.n == '0) begin
                        n_state = S_DONE;
                    end else if (i_start.n == CB'(1)) begin
                        n_state = S_SRD;
                    end else begin
                        n_state = S_PASS;
                    end
                end
            end
            S_PASS:  n_state = S_RDP0;
            S_RDP0:  n_state = S_RDQ0;
            S_RDQ0:  n_state = S_WAITQ;
            S_WAITQ: n_state = S_MERGE;
            S_MERGE: n_state = ((r_k + 1'b1) == r_hi) ? S_NEXT : S_LOAD;
            S_LOAD:  n_state = S_MERGE;
            S_NEXT: begin
                if (lo_next >= n_wide && w_next >= n_wide) begin
                    n_state = S_SRD;
                end else begin
                    n_state = S_PASS;
                end
            end
            S_SRD:   n_state = S_SGET;
            S_SGET:  n_state = S_FRD;
            S_FRD:   n_state = S_FCHK;
            S_FCHK: begin
                if (p_rdata != r_x) begin
                    n_state = S_FHALF;
                end else if (r_which) begin
                    n_state = S_CMPR;
                end else begin
                    n_state = S_FRD;
                end
            end
            S_FHALF: n_state = S_FRD;
            S_CMPR:  n_state = (r_ra == r_rb) ? S_NEXTE : S_SZB;
            S_SZB:   n_state = S_SZW;
            S_SZW:   n_state = S_UNI;
            S_UNI:   n_state = S_NEXTE;
            S_NEXTE: n_state = ((r_i + 1'b1) == r_n) ? S_DONE : S_SRD;
            S_DONE:  if (i_ack) n_state = S_CLR;
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_c     <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_c <= r_c + 1'b1;
            end
            if (r_state == S_IDLE && i_start.go) begin
                r_sum <= '0;
            end else if (r_state == S_UNI) begin
                r_sum <= r_sum + kmw_pkg::SUM_BITS'(r_e.w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n     <= i_start.n;
                r_width <= PB'(1);
                r_lo    <= '0;
                r_src_b <= 1'b0;
                r_i     <= '0;
            end
            S_PASS: begin
                r_mid <= (mid_raw < n_wide) ? mid_raw : n_wide;
                r_hi  <= (hi_raw < n_wide) ? hi_raw : n_wide;
                r_p   <= r_lo;
                r_q   <= (mid_raw < n_wide) ? mid_raw : n_wide;
                r_k   <= r_lo;
            end
            S_RDQ0:  r_dp <= rd_e;
            S_WAITQ: r_dq <= rd_e;
            S_MERGE: begin
                r_took_q <= take_q;
                r_k      <= r_k + 1'b1;
                if (take_q) begin
                    r_q <= r_q + 1'b1;
                end else begin
                    r_p <= r_p + 1'b1;
                end
            end
            S_LOAD: begin
                if (r_took_q) begin
                    r_dq <= rd_e;
                end else begin
                    r_dp <= rd_e;
                end
            end
            S_NEXT: begin
                if (lo_next >= n_wide) begin
                    r_lo    <= '0;
                    r_width <= w_next;
                    r_src_b <= !r_src_b;
                end else begin
                    r_lo <= lo_next;
                end
            end
            S_SGET: begin
                r_e     <= rd_e;
                r_x     <= rd_e.na;
                r_which <= 1'b0;
            end
            S_FCHK: begin
                if (p_rdata == r_x) begin
                    if (r_which) begin
                        r_rb <= r_x;
                    end else begin
                        r_ra    <= r_x;
                        r_x     <= r_e.nb;
                        r_which <= 1'b1;
                    end
                end
            end
            S_FHALF: r_x  <= p_rdata;
            S_SZB:   r_sa <= s_rdata;
            S_SZW:   r_sb <= s_rdata;
            S_NEXTE: r_i  <= r_i + 1'b1;
            default: begin
            end
        endcase
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_stat.sum  = r_sum;

endmodule
`default_nettype wire

// ===== sim/kruskal_mst_weight_top_tb.sv =====
// Testbench for kruskal_mst_weight_top: edges go in, forest weight and status come out.
// A local Kruskal predictor with union by size, or a directed expected value, checks every result beat field by field.
// Depends on kmw_pkg and the kruskal_mst_weight_top RTL.
`timescale 1ns / 100ps
`default_nettype none
module kruskal_mst_weight_top_tb;

    typedef struct {
        logic [kmw_pkg::NODE_BITS-1:0]          na;
        logic [kmw_pkg::NODE_BITS-1:0]          nb;
        logic signed [kmw_pkg::WEIGHT_BITS-1:0] w;
    } t_edge_item;

    typedef struct {
        logic signed [kmw_pkg::SUM_BITS-1:0]  weight;
        logic [kmw_pkg::STATUS_BITS-1:0]      status;
    } t_forest;

    typedef struct {
        int                                     nc;
        logic [kmw_pkg::NODE_BITS-1:0]          na;
        logic [kmw_pkg::NODE_BITS-1:0]          nb;
        logic signed [kmw_pkg::WEIGHT_BITS-1:0] w;
        bit                                     last;
        bit                                     typed;
        int                                     ew;
        int                                     est;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [kmw_pkg::NODE_BITS-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [kmw_pkg::NODE_BITS-1:0] i_node_a = '0;
    logic [kmw_pkg::NODE_BITS-1:0] i_node_b = '0;
    logic signed [kmw_pkg::WEIGHT_BITS-1:0] i_edge_weight = '0;
    logic i_last_edge = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [kmw_pkg::SUM_BITS-1:0] o_tree_weight;
    logic [kmw_pkg::STATUS_BITS-1:0] o_status;

    kruskal_mst_weight_top i_dut (.*);

    always #1 i_clk = ~i_clk;

    int node_limit = 1023;
    t_edge_item graph_edges[$];
    logic [kmw_pkg::STATUS_BITS-1:0] graph_flags = '0;
    t_forest pending_forests[$];
    int set_parent[1024];
    int set_size[1024];
    int fail_count = 0;
    bit hold_request = 1'b0;

    function automatic int find_set(int x);
        while (set_parent[x] != x) begin
            set_parent[x] = set_parent[set_parent[x]];
            x = set_parent[x];
        end
        return x;
    endfunction

    function automatic t_forest spanning_forest();
        t_edge_item sorted[$];
        t_edge_item e;
        longint total;
        int ra, rb, j;
        t_forest r;
        total = 0;
        sorted = graph_edges;
        for (int i = 1; i < sorted.size(); i++) begin
            e = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j].w > e.w) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = e;
        end
        for (int i = 0; i < 1024; i++) begin
            set_parent[i] = i;
            set_size[i] = 1;
        end
        foreach (sorted[i]) begin
            ra = find_set(int'(sorted[i].na));
            rb = find_set(int'(sorted[i].nb));
            if (ra != rb) begin
                total += sorted[i].w;
                if (set_size[ra] < set_size[rb]) begin
                    set_parent[ra] = rb;
                    set_size[rb] += set_size[ra];
                end else begin
                    set_parent[rb] = ra;
                    set_size[ra] += set_size[rb];
                end
            end
        end
        r.weight = total[kmw_pkg::SUM_BITS-1:0];
        r.status = graph_flags;
        return r;
    endfunction

    // Applies one accepted edge beat; returns 1 and the forest when the graph closes.
    function automatic bit absorb_edge(t_edge_item e, bit last, output t_forest r);
        if (e.na > node_limit || e.nb > node_limit)
            graph_flags[kmw_pkg::FLAG_RANGE] = 1'b1;
        else if (graph_edges.size() >= kmw_pkg::MAX_EDGES)
            graph_flags[kmw_pkg::FLAG_DROP] = 1'b1;
        else
            graph_edges = {graph_edges, e};
        if (!last)
            return 1'b0;
        r = spanning_forest();
        graph_edges.delete();
        graph_flags = '0;
        return 1'b1;
    endfunction

    task automatic write_node_limit(int nc);
        i_in_valid <= 1'b0;
        wait (pending_forests.size() == 0);
        repeat (1100) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= nc[kmw_pkg::NODE_BITS-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        node_limit = nc;
    endtask

    task automatic send_edge(t_edge_item e, bit last, bit typed, t_forest typed_res);
        t_forest r;
        int gap;
        i_in_valid <= 1'b1;
        i_node_a <= e.na;
        i_node_b <= e.nb;
        i_edge_weight <= e.w;
        i_last_edge <= last;
        do @(posedge i_clk); while (o_in_stall);
        if (absorb_edge(e, last, r))
            pending_forests = {pending_forests, typed ? typed_res : r};
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin : receiver
        int n;
        t_forest want;
        forever begin
            n = $urandom_range(0, 5);
            if (hold_request) begin
                n = 3000;
                hold_request = 1'b0;
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            if (pending_forests.size() == 0) begin
                $error("unexpected result beat: tree_weight %0d status %0d",
                       o_tree_weight, o_status);
                fail_count++;
            end else begin
                want = pending_forests.pop_front();
                if (o_tree_weight !== want.weight) begin
                    $error("tree_weight: expected %0d, actual %0d", want.weight, o_tree_weight);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_dir_row dir_tbl[$];
        int limits[$];
        t_edge_item e;
        t_forest tr;
        int span, edges, nc;
        dir_tbl = '{
            '{1023, 0, 1023, -32768, 1, 1, -32768, 0},
            '{1023, 1023, 1023, 32767, 1, 1, 0, 0},
            '{1023, 1023, 0, 32767, 1, 1, 32767, 0},
            '{1023, 682, 341, 0, 1, 1, 0, 0},
            '{5, 6, 0, 5, 1, 1, 0, 2},
            '{5, 0, 1, 10, 0, 0, 0, 0},
            '{5, 1, 2, -3, 0, 0, 0, 0},
            '{5, 0, 2, 7, 0, 0, 0, 0},
            '{5, 2, 6, 9, 0, 0, 0, 0},
            '{5, 2, 2, -100, 1, 1, 4, 2},
            '{0, 0, 0, -5, 1, 1, 0, 0},
            '{0, 1, 0, 3, 1, 1, 0, 2},
            '{1, 0, 1, 100, 0, 0, 0, 0},
            '{1, 1, 0, 50, 0, 0, 0, 0},
            '{1, 0, 1, -7, 1, 1, -7, 0},
            '{7, 0, 1, 4, 0, 0, 0, 0},
            '{7, 1, 2, 4, 0, 0, 0, 0},
            '{7, 2, 3, -2, 0, 0, 0, 0},
            '{7, 3, 0, 1, 0, 0, 0, 0},
            '{7, 4, 5, 9, 0, 0, 0, 0},
            '{7, 5, 7, 9, 0, 0, 0, 0},
            '{7, 7, 4, 9, 0, 0, 0, 0},
            '{7, 0, 7, 30, 1, 0, 0, 0}
        };
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].nc != node_limit)
                write_node_limit(dir_tbl[i].nc);
            e = '{dir_tbl[i].na, dir_tbl[i].nb, dir_tbl[i].w};
            tr.weight = kmw_pkg::SUM_BITS'(dir_tbl[i].ew);
            tr.status = kmw_pkg::STATUS_BITS'(dir_tbl[i].est);
            send_edge(e, dir_tbl[i].last, dir_tbl[i].typed, tr);
        end

        // Overfill the edge store, with one out-of-range edge, so both flags are raised.
        write_node_limit(1000);
        for (int i = 0; i <= 4097; i++) begin
            e.na = kmw_pkg::NODE_BITS'($urandom_range(0, 1000));
            e.nb = kmw_pkg::NODE_BITS'($urandom_range(0, 1000));
            e.w = kmw_pkg::WEIGHT_BITS'($urandom);
            if (i == 100)
                e.na = kmw_pkg::NODE_BITS'(1001);
            send_edge(e, i == 4097, 1'b0, tr);
        end

        limits = '{1023, 0, 1, 15, 1023, $urandom_range(2, 1022), 1023};
        foreach (limits[p]) begin
            write_node_limit(limits[p]);
            for (int g = 0; g < 12; g++) begin
                if (p == 3 && g == 4)
                    hold_request = 1'b1;
                nc = node_limit;
                span = ($urandom_range(0, 3) == 0) ? nc : $urandom_range(0, nc < 31 ? nc : 31);
                edges = $urandom_range(0, 15);
                for (int k = 0; k <= edges; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        e.na = kmw_pkg::NODE_BITS'($urandom);
                        e.nb = kmw_pkg::NODE_BITS'($urandom);
                    end else begin
                        e.na = kmw_pkg::NODE_BITS'($urandom_range(0, span));
                        e.nb = kmw_pkg::NODE_BITS'($urandom_range(0, span));
                    end
                    case ($urandom_range(0, 7))
                        0: e.w = 16'sh7fff;
                        1: e.w = 16'sh8000;
                        2: e.w = kmw_pkg::WEIGHT_BITS'($urandom_range(0, 7));
                        default: e.w = kmw_pkg::WEIGHT_BITS'($urandom);
                    endcase
                    send_edge(e, k == edges, 1'b0, tr);
                end
            end
        end
        i_in_valid <= 1'b0;
        wait (pending_forests.size() == 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
